FILE: sv/sfdc_pkg.sv
// Shared types, constants and helpers for the sign flip divergence checker.
`timescale 1ns / 1ps

package sfdc_pkg;

	// Field widths
	localparam int CNT_W = 21;
	localparam int VAL_W = 64;
	localparam int THR_W = 18;
	localparam int PW    = 2 * CNT_W;
	localparam int PCT_W = CNT_W + 7;
	localparam int OUT_W = 152;

	// Saturation limit: the point budget, or the field maximum if that is smaller
	localparam longint unsigned SFDC_MAX_POINTS = 64'd1048576;
	localparam longint unsigned FIELD_MAX       = (64'd1 << CNT_W) - 64'd1;
	localparam logic [CNT_W-1:0] CNT_CAP = (SFDC_MAX_POINTS < FIELD_MAX) ?
		CNT_W'(SFDC_MAX_POINTS) : CNT_W'(FIELD_MAX);

	// Register reset values and the positive share factor
	localparam logic [THR_W-1:0] THRESH_RST = THR_W'(32768);
	localparam logic             FATAL_RST  = 1'b1;
	localparam logic [PCT_W-1:0] PCT_SCALE  = PCT_W'(100);
	localparam int               FRAC_W     = 16;

	// Register indexes
	localparam logic CFG_THRESH = 1'b0;
	localparam logic CFG_FATAL  = 1'b1;

	typedef enum logic [1:0] {
		ST_PASS    = 2'd0,
		ST_WARN    = 2'd1,
		ST_FATAL   = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SG_NONE = 2'd0,
		SG_POS  = 2'd1,
		SG_NEG  = 2'd2
	} sign_t;

	// Table-wide counts carried down the pipe with a table end beat
	typedef struct packed {
		logic [CNT_W-1:0] total;
		logic [CNT_W-1:0] positive;
		logic [CNT_W-1:0] nonfinite;
		logic [CNT_W-1:0] slices;
	} tally_t;

	// A slice close leaving the counter stage
	typedef struct packed {
		logic             close;
		logic             tend;
		logic [CNT_W-1:0] num;
		logic [CNT_W-1:0] den;
		tally_t           tally;
	} close_t;

	// Everything the status stage needs for one table
	typedef struct packed {
		tally_t           tally;
		logic [CNT_W-1:0] bad;
		logic [CNT_W-1:0] wnum;
		logic [CNT_W-1:0] wden;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v < CNT_CAP) ? v + CNT_W'(1) : CNT_CAP;
	endfunction

endpackage

FILE: sv/sfdc_count.sv
// Input register, value classification and per-table and per-slice counters.
`timescale 1ns / 1ps

module sfdc_count (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  logic [sfdc_pkg::VAL_W-1:0] in_value,
	input  logic                   in_slice_end,
	input  logic                   in_table_end,
	output logic                   v_s2,
	output sfdc_pkg::close_t       cl_s2
);
	import sfdc_pkg::*;

	logic             v_s1;
	logic [VAL_W-1:0] val_s1;
	logic             send_s1;
	logic             tend_s1;

	logic [CNT_W-1:0] total_q, pos_q, nf_q, slices_q, flip_q, point_q;
	sign_t            last_q;

	logic             nonfin, signed_val, close;
	sign_t            sgn;
	logic [CNT_W-1:0] total_n, pos_n, nf_n, slices_n, flip_n, point_n;
	sign_t            last_n;

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s1  <= in_value;
			send_s1 <= in_slice_end;
			tend_s1 <= in_table_end;
		end
	end

	// Classify the value and work out the next counts
	always_comb begin
		nonfin     = &val_s1[VAL_W-2:VAL_W-12];
		signed_val = !nonfin && (|val_s1[VAL_W-2:0]);
		sgn        = val_s1[VAL_W-1] ? SG_NEG : SG_POS;
		close      = send_s1 || tend_s1;

		total_n  = sat_inc(total_q);
		point_n  = sat_inc(point_q);
		nf_n     = nonfin ? sat_inc(nf_q) : nf_q;
		pos_n    = (signed_val && sgn == SG_POS) ? sat_inc(pos_q) : pos_q;
		flip_n   = (signed_val && last_q != SG_NONE && last_q != sgn) ?
			sat_inc(flip_q) : flip_q;
		last_n   = signed_val ? sgn : last_q;
		slices_n = close ? sat_inc(slices_q) : slices_q;
	end

	// Advance the counters; clear the slice on a close, everything on a table end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			pos_q    <= '0;
			nf_q     <= '0;
			slices_q <= '0;
			flip_q   <= '0;
			point_q  <= '0;
			last_q   <= SG_NONE;
		end else if (adv && v_s1) begin
			if (tend_s1) begin
				total_q  <= '0;
				pos_q    <= '0;
				nf_q     <= '0;
				slices_q <= '0;
			end else begin
				total_q  <= total_n;
				pos_q    <= pos_n;
				nf_q     <= nf_n;
				slices_q <= slices_n;
			end
			if (close) begin
				flip_q  <= '0;
				point_q <= '0;
				last_q  <= SG_NONE;
			end else begin
				flip_q  <= flip_n;
				point_q <= point_n;
				last_q  <= last_n;
			end
		end
	end

	// Hand the closed slice and the table snapshot to the ratio stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cl_s2.close           <= close && (point_n > CNT_W'(1));
			cl_s2.tend            <= tend_s1;
			cl_s2.num             <= flip_n;
			cl_s2.den             <= point_n - CNT_W'(1);
			cl_s2.tally.total     <= total_n;
			cl_s2.tally.positive  <= pos_n;
			cl_s2.tally.nonfinite <= nf_n;
			cl_s2.tally.slices    <= slices_n;
		end
	end

endmodule

FILE: sv/sfdc_ratio.sv
// Exact worst flip ratio tracking and per-slice threshold check.
`timescale 1ns / 1ps

module sfdc_ratio (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  logic                       v_s2,
	input  sfdc_pkg::close_t           cl_s2,
	input  logic [sfdc_pkg::THR_W-1:0] thresh,
	output logic                       res_v_s4,
	output sfdc_pkg::res_t             res_s4
);
	import sfdc_pkg::*;

	logic             v_s3, close_s3, tend_s3, wzero_s3;
	logic [CNT_W-1:0] num_s3, den_s3;
	logic [PW-1:0]    pa_s3, pb_s3, pt_s3;
	tally_t           tally_s3;

	logic [CNT_W-1:0] wnum_q, wden_q, bad_q;

	logic             larger, over;
	logic [CNT_W-1:0] wnum_n, wden_n, bad_n;

	// Cross products against the current worst, and the threshold product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			close_s3 <= cl_s2.close;
			tend_s3  <= cl_s2.tend;
			num_s3   <= cl_s2.num;
			den_s3   <= cl_s2.den;
			tally_s3 <= cl_s2.tally;
			wzero_s3 <= (wden_q == '0);
			pa_s3    <= PW'(cl_s2.num) * PW'(wden_q);
			pb_s3    <= PW'(wnum_q) * PW'(cl_s2.den);
			pt_s3    <= PW'(thresh) * PW'(cl_s2.den);
		end
	end

	// Compare and pick the next worst ratio and bad slice count
	always_comb begin
		larger = wzero_s3 ? (num_s3 != '0) : (pa_s3 > pb_s3);
		over   = PW'({num_s3, {FRAC_W{1'b0}}}) > pt_s3;
		wnum_n = (close_s3 && larger) ? num_s3 : wnum_q;
		wden_n = (close_s3 && larger) ? den_s3 : wden_q;
		bad_n  = (close_s3 && over) ? sat_inc(bad_q) : bad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wnum_q <= '0;
			wden_q <= '0;
			bad_q  <= '0;
		end else if (adv && v_s3) begin
			if (tend_s3) begin
				wnum_q <= '0;
				wden_q <= '0;
				bad_q  <= '0;
			end else begin
				wnum_q <= wnum_n;
				wden_q <= wden_n;
				bad_q  <= bad_n;
			end
		end
	end

	// Pass the finished table on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s4 <= 1'b0;
		end else if (adv) begin
			res_v_s4 <= v_s3 && tend_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s4.tally <= tally_s3;
			res_s4.bad   <= bad_n;
			res_s4.wnum  <= wnum_n;
			res_s4.wden  <= wden_n;
		end
	end

endmodule

FILE: sv/sfdc_status.sv
// Table verdict and the output register.
`timescale 1ns / 1ps

module sfdc_status (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       res_v_s4,
	input  sfdc_pkg::res_t             res_s4,
	input  logic [sfdc_pkg::THR_W-1:0] thresh,
	input  logic                       fatal,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [sfdc_pkg::OUT_W-1:0] out_data,
	output logic                       stall
);
	import sfdc_pkg::*;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic [PW-1:0]    pw;
	logic [PCT_W-1:0] pos_pct;
	logic             divergent;
	status_t          status;

	// Work out the verdict
	always_comb begin
		pw        = PW'(thresh) * PW'(res_s4.wden);
		pos_pct   = PCT_W'(res_s4.tally.positive) * PCT_SCALE;
		divergent = (pos_pct > PCT_W'(res_s4.tally.total)) ||
			(PW'({res_s4.wnum, {FRAC_W{1'b0}}}) > pw);
		if (res_s4.tally.nonfinite != '0) begin
			status = ST_INVALID;
		end else if (divergent) begin
			status = fatal ? ST_FATAL : ST_WARN;
		end else begin
			status = ST_PASS;
		end
	end

	// Hold the pipe only when a new result finds the output still full
	assign stall = res_v_s4 && out_valid_q && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_v_s4 && !stall) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_v_s4 && !stall) begin
			out_data_q <= OUT_W'({res_s4.wden, res_s4.wnum, res_s4.tally.slices,
				res_s4.bad, res_s4.tally.nonfinite, res_s4.tally.positive,
				res_s4.tally.total, status});
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: sv/sign_flip_divergence_checker.sv
// Top level of the sign flip divergence checker.
// Takes one double value per beat, every cycle while not stalled, and reports one status beat per table. The
// table end beat is loaded into the input register, and its result then passes through the
// counter stage, ratio product stage, ratio compare stage and verdict stage in that order.
// The counter update sets the rate of one beat per clock while the pipe is not stalled. The
// input is held back only while a second finished result waits behind one that has not been
// taken. Registers may be written only while the pipe is empty.
`timescale 1ns / 1ps

module sign_flip_divergence_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [63:0]                s_tdata,   // value_bits
	input  logic                       s_tuser,   // slice_end
	input  logic                       s_tlast,   // table_end
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// check_status, total_points, positive_points, nonfinite_points, bad_slice_count,
	// slice_count, worst_flips, worst_span, zero pad
	output logic [151:0]               m_tdata,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [17:0]                cfg_wdata
);
	import sfdc_pkg::*;

	logic             adv, stall;
	logic             v_s2, res_v_s4;
	close_t           cl_s2;
	res_t             res_s4;
	logic [THR_W-1:0] thresh_q;
	logic             fatal_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
			fatal_q  <= FATAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_THRESH: thresh_q <= cfg_wdata;
				CFG_FATAL:  fatal_q  <= cfg_wdata[0];
				default:    thresh_q <= thresh_q;
			endcase
		end
	end

	assign adv      = !stall;
	assign s_tready = adv;

	sfdc_count u_count (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (s_tvalid),
		.in_value     (s_tdata),
		.in_slice_end (s_tuser),
		.in_table_end (s_tlast),
		.v_s2         (v_s2),
		.cl_s2        (cl_s2)
	);

	sfdc_ratio u_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_s2     (v_s2),
		.cl_s2    (cl_s2),
		.thresh   (thresh_q),
		.res_v_s4 (res_v_s4),
		.res_s4   (res_s4)
	);

	sfdc_status u_status (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_v_s4  (res_v_s4),
		.res_s4    (res_s4),
		.thresh    (thresh_q),
		.fatal     (fatal_q),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.stall     (stall)
	);

endmodule

FILE: sv/sfdc_checker.sv
// Port-level checks on the sign flip divergence checker, bound to the top level.
`timescale 1ns / 1ps

module sfdc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [63:0]  s_tdata,
	input logic         s_tuser,
	input logic         s_tlast,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [151:0] m_tdata,
	input logic         cfg_we,
	input logic         cfg_index,
	input logic [17:0]  cfg_wdata
);
	import sfdc_pkg::*;

	// Hold a result beat until it is taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped before it was taken");

	// Report invalid exactly when non-finite values were seen
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[1:0] == ST_INVALID) == (m_tdata[64:44] != 21'd0)))
		else $error("status disagrees with the non-finite count");

	// A zero span carries no flips
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[148:128] == 21'd0) |-> (m_tdata[127:107] == 21'd0))
		else $error("worst ratio has flips but no span");

	// Keep the counts consistent with one another
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[22:2] != 21'd0) && (m_tdata[43:23] <= m_tdata[22:2]) &&
			(m_tdata[64:44] <= m_tdata[22:2]) && (m_tdata[106:86] != 21'd0) &&
			(m_tdata[85:65] <= m_tdata[106:86]))
		else $error("result counts are inconsistent");

endmodule

bind sign_flip_divergence_checker sfdc_checker u_sfdc_checker (.*);
